// File: sv/srp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srp_pkg: shared types and constants of the status record parser
// Record text constants, size limits, handshake command/status bundles
// between the controller and the datapath, and output codes.
// ----------------------------------------------------------------------------
package srp_pkg;

  // Size limits
  localparam int SERIAL_MAX = 32;
  localparam int MAX_BYTES  = 256;

  // Derived widths
  localparam int SER_AW = (SERIAL_MAX > 1) ? $clog2(SERIAL_MAX) : 1;
  localparam int SER_CW = $clog2(SERIAL_MAX + 1);
  localparam int BT_W   = $clog2(MAX_BYTES + 2);
  localparam int COL_W  = 9;

  localparam logic [COL_W-1:0]  COL_SAT   = 9'd511;
  localparam logic [BT_W-1:0]   BYTES_LIM = BT_W'(MAX_BYTES);
  localparam logic [SER_CW-1:0] SER_LIM   = SER_CW'(SERIAL_MAX);

  // Line prefix lengths, header length and timestamp digit limit
  localparam logic [COL_W-1:0] HDR_LEN = 9'd19;
  localparam logic [COL_W-1:0] SER_PFX = 9'd7;
  localparam logic [COL_W-1:0] CON_PFX = 9'd12;
  localparam logic [COL_W-1:0] UPD_PFX = 9'd20;
  localparam logic [4:0]       DIG_MAX = 5'd20;

  localparam logic [7:0] CH_NL = 8'h0A;

  // Line texts, first character in the top byte
  localparam logic [8*19-1:0] HDR_TEXT =
    152'h46414345504C4154455F5354415455535F5631;
  localparam logic [8*7-1:0]  SER_TEXT = "serial=";
  localparam logic [8*12-1:0] CON_TEXT = 96'h64617461706C69636974793D;
  localparam logic [8*20-1:0] UPD_TEXT =
    160'h757064617465645F626F6F7474696D655F6D733D;
  localparam logic [8*9-1:0]  KW0_TEXT = "connected";
  localparam logic [8*12-1:0] KW1_TEXT = "disconnected";
  localparam logic [8*7-1:0]  KW2_TEXT = "unknown";

  // Output codes
  localparam logic [1:0] VIS_HIDDEN = 2'd0;
  localparam logic [1:0] VIS_STALE  = 2'd1;
  localparam logic [1:0] VIS_FRESH  = 2'd2;

  localparam logic [1:0] CONN_UNKNOWN      = 2'd0;
  localparam logic [1:0] CONN_CONNECTED    = 2'd1;
  localparam logic [1:0] CONN_DISCONNECTED = 2'd2;

  // Keyword slots
  localparam logic [1:0] KW_CONN  = 2'd0;
  localparam logic [1:0] KW_DISC  = 2'd1;
  localparam logic [1:0] KW_UNKN  = 2'd2;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_SERIAL,
    PH_LINK,
    PH_STAMP,
    PH_DONE
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_JUDGE,
    ST_READ,
    ST_SEND_CHAR,
    ST_SEND_SUM
  } state_e;

  // Controller -> datapath
  typedef struct packed {
    logic take;      // record byte accepted
    logic load_now;  // final byte: capture time
    logic check;     // future test and age
    logic judge;     // visibility decision
    logic rd;        // serial store read
    logic next_idx;  // advance serial position
    logic clear;     // back to reset parse state
    logic sum_sel;   // output beat is the summary
  } srp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic len_zero;
    logic idx_last;
  } srp_sts_t;

  // Character of a fixed prefix text
  function automatic logic [7:0] hdr_char(input logic [4:0] i);
    logic [7:0] c;
    c = 8'h00;
    if (i < 5'd19) c = HDR_TEXT[8*(18 - int'(i)) +: 8];
    return c;
  endfunction

  function automatic logic [7:0] ser_char(input logic [2:0] i);
    logic [7:0] c;
    c = 8'h00;
    if (i < 3'd7) c = SER_TEXT[8*(6 - int'(i)) +: 8];
    return c;
  endfunction

  function automatic logic [7:0] con_char(input logic [3:0] i);
    logic [7:0] c;
    c = 8'h00;
    if (i < 4'd12) c = CON_TEXT[8*(11 - int'(i)) +: 8];
    return c;
  endfunction

  function automatic logic [7:0] upd_char(input logic [4:0] i);
    logic [7:0] c;
    c = 8'h00;
    if (i < 5'd20) c = UPD_TEXT[8*(19 - int'(i)) +: 8];
    return c;
  endfunction

  // Keyword tables
  function automatic logic [COL_W-1:0] kw_len(input logic [1:0] k);
    logic [COL_W-1:0] n;
    case (k)
      KW_CONN: n = 9'd9;
      KW_DISC: n = 9'd12;
      KW_UNKN: n = 9'd7;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [3:0] i);
    logic [7:0] c;
    c = 8'h00;
    case (k)
      KW_CONN: if (i < 4'd9)  c = KW0_TEXT[8*(8 - int'(i)) +: 8];
      KW_DISC: if (i < 4'd12) c = KW1_TEXT[8*(11 - int'(i)) +: 8];
      KW_UNKN: if (i < 4'd7)  c = KW2_TEXT[8*(6 - int'(i)) +: 8];
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [1:0] kw_code(input logic [1:0] k);
    logic [1:0] r;
    case (k)
      KW_CONN: r = CONN_CONNECTED;
      KW_DISC: r = CONN_DISCONNECTED;
      default: r = CONN_UNKNOWN;
    endcase
    return r;
  endfunction

  // Allowed serial characters
  function automatic logic serial_char_ok(input logic [7:0] c);
    return (c inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39],
                      8'h2E, 8'h5F, 8'h3A, 8'h2F, 8'h2D});
  endfunction

endpackage

// File: sv/status_record_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// status_record_parser: four-line status record checker
// Byte-wise parser with serial extraction and freshness summary.
// ----------------------------------------------------------------------------
// Usage: record bytes are taken one per cycle, each checked as it arrives.
// The byte flagged last_byte_i starts the summary: the CHECK and JUDGE
// states evaluate the timestamp against now_ms_i and the staleness
// threshold register, then each serial character goes out as one beat,
// read in ST_READ and sent in ST_SEND_CHAR (the serial store has a
// registered read port), followed by one summary beat with final_item_o
// set. A hidden record sends no serial characters. in_stall_o is high
// after the last byte until the summary beat is taken. Write the
// threshold only while no record is in flight.
// ----------------------------------------------------------------------------
module status_record_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Threshold register
  input  logic        cfg_we_i,
  input  logic [63:0] cfg_wdata_i,
  // Byte input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  input  logic        last_byte_i,
  input  logic [63:0] now_ms_i,
  // Result output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  serial_char_o,
  output logic [4:0]  serial_index_o,
  output logic [5:0]  serial_length_o,
  output logic [1:0]  visibility_o,
  output logic [1:0]  connection_o,
  output logic [63:0] updated_ms_o,
  output logic        final_item_o
);
  import srp_pkg::*;

  srp_cmd_t cmd;
  srp_sts_t sts;

  // Sequencer
  srp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_byte_i (last_byte_i),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o)
  );

  // Parser and evaluation datapath
  srp_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_byte_i       (in_byte_i),
    .now_ms_i        (now_ms_i),
    .serial_char_o   (serial_char_o),
    .serial_index_o  (serial_index_o),
    .serial_length_o (serial_length_o),
    .visibility_o    (visibility_o),
    .connection_o    (connection_o),
    .updated_ms_o    (updated_ms_o),
    .final_item_o    (final_item_o)
  );

endmodule

// File: sv/srp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srp_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module srp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/srp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srp_ctrl: status record parser controller
// Takes record bytes while idle, then sequences evaluation, serial beats
// and the summary beat.
// ----------------------------------------------------------------------------
module srp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              last_byte_i,
  input  logic              out_stall_i,
  input  srp_pkg::srp_sts_t sts_i,
  output srp_pkg::srp_cmd_t cmd_o,
  output logic              in_stall_o,
  output logic              out_valid_o
);
  import srp_pkg::*;

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && last_byte_i) state_d = ST_CHECK;
      end
      ST_CHECK: state_d = ST_JUDGE;
      ST_JUDGE: state_d = ST_READ;
      ST_READ: begin
        state_d = sts_i.len_zero ? ST_SEND_SUM : ST_SEND_CHAR;
      end
      ST_SEND_CHAR: begin
        if (!out_stall_i) state_d = sts_i.idx_last ? ST_SEND_SUM : ST_READ;
      end
      ST_SEND_SUM: begin
        if (!out_stall_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs and commands
  always_comb begin
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o     = 1'b0;
        cmd_o.take     = in_valid_i;
        cmd_o.load_now = in_valid_i && last_byte_i;
      end
      ST_CHECK: cmd_o.check = 1'b1;
      ST_JUDGE: cmd_o.judge = 1'b1;
      ST_READ:  cmd_o.rd = !sts_i.len_zero;
      ST_SEND_CHAR: begin
        out_valid_o    = 1'b1;
        cmd_o.next_idx = !out_stall_i && !sts_i.idx_last;
      end
      ST_SEND_SUM: begin
        out_valid_o   = 1'b1;
        cmd_o.sum_sel = 1'b1;
        cmd_o.clear   = !out_stall_i;
      end
      default: in_stall_o = 1'b1;
    endcase
  end

endmodule

// File: sv/srp_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srp_dp: status record parser datapath
// Per-byte line checks, serial store, timestamp accumulator, age and
// visibility evaluation, output fields.
// ----------------------------------------------------------------------------
module srp_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  srp_pkg::srp_cmd_t cmd_i,
  output srp_pkg::srp_sts_t sts_o,
  input  logic              cfg_we_i,
  input  logic [63:0]       cfg_wdata_i,
  input  logic [7:0]        in_byte_i,
  input  logic [63:0]       now_ms_i,
  output logic [7:0]        serial_char_o,
  output logic [4:0]        serial_index_o,
  output logic [5:0]        serial_length_o,
  output logic [1:0]        visibility_o,
  output logic [1:0]        connection_o,
  output logic [63:0]       updated_ms_o,
  output logic              final_item_o
);
  import srp_pkg::*;

  // Parse state
  phase_e             phase_q, phase_d;
  logic [COL_W-1:0]   col_q, col_d;
  logic [BT_W-1:0]    bt_q, bt_d;
  logic               bad_q, bad_d;
  logic [SER_CW-1:0]  cnt_q, cnt_d;
  logic [2:0]         alive_q, alive_d;
  logic [63:0]        acc_q, acc_d;
  logic [4:0]         dig_q, dig_d;

  // Evaluation and emission state
  logic [63:0]        stale_q;
  logic [63:0]        now_q;
  logic               future_q;
  logic [63:0]        diff_q;
  logic [1:0]         vis_q, conn_q;
  logic [SER_CW-1:0]  len_q;
  logic [63:0]        upd_q;
  logic [SER_AW-1:0]  idx_q;

  // Per-byte helpers
  logic               nl, over, fail, step;
  logic               ser_we;
  logic [COL_W-1:0]   pos;
  logic [2:0]         match;
  logic [67:0]        acc_x10;
  logic [7:0]         ram_rdata;
  logic               eval_ok;
  logic [1:0]         conn_sel;

  assign nl      = (in_byte_i == CH_NL);
  assign pos     = col_q - CON_PFX;
  assign acc_x10 = ({4'd0, acc_q} << 3) + ({4'd0, acc_q} << 1)
                   + 68'(in_byte_i[3:0]);

  // Byte parser
  always_comb begin
    phase_d = phase_q;
    col_d   = col_q;
    bt_d    = bt_q;
    bad_d   = bad_q;
    cnt_d   = cnt_q;
    alive_d = alive_q;
    acc_d   = acc_q;
    dig_d   = dig_q;
    over    = 1'b0;
    fail    = 1'b0;
    step    = 1'b0;
    ser_we  = 1'b0;
    match   = 3'b000;
    if (cmd_i.clear) begin
      phase_d = PH_HEADER;
      col_d   = '0;
      bt_d    = '0;
      bad_d   = 1'b0;
      cnt_d   = '0;
      alive_d = 3'b111;
      acc_d   = '0;
      dig_d   = '0;
    end else if (cmd_i.take) begin
      if (bt_q <= BYTES_LIM) bt_d = bt_q + BT_W'(1);
      over = (bt_d > BYTES_LIM);
      if (over) begin
        bad_d = 1'b1;
      end else if (!bad_q) begin
        case (phase_q)
          PH_HEADER: begin
            if (nl) begin
              if (col_q != HDR_LEN) begin
                fail = 1'b1;
              end else begin
                phase_d = PH_SERIAL;
                col_d   = '0;
              end
            end else if (col_q >= HDR_LEN || in_byte_i != hdr_char(col_q[4:0])) begin
              fail = 1'b1;
            end else begin
              step = 1'b1;
            end
          end
          PH_SERIAL: begin
            if (col_q < SER_PFX) begin
              fail = nl || (in_byte_i != ser_char(col_q[2:0]));
              step = !fail;
            end else if (nl) begin
              if (cnt_q == '0) begin
                fail = 1'b1;
              end else begin
                phase_d = PH_LINK;
                col_d   = '0;
              end
            end else if (!serial_char_ok(in_byte_i) || cnt_q >= SER_LIM) begin
              fail = 1'b1;
            end else begin
              ser_we = 1'b1;
              cnt_d  = cnt_q + SER_CW'(1);
              step   = 1'b1;
            end
          end
          PH_LINK: begin
            if (col_q < CON_PFX) begin
              fail = nl || (in_byte_i != con_char(col_q[3:0]));
              step = !fail;
            end else if (nl) begin
              for (int k = 0; k < 3; k++) begin
                if (alive_q[k] && kw_len(2'(k)) == pos) match = 3'(1 << k);
              end
              if (match == 3'b000) begin
                fail = 1'b1;
              end else begin
                alive_d = match;
                phase_d = PH_STAMP;
                col_d   = '0;
              end
            end else begin
              for (int k = 0; k < 3; k++) begin
                if (pos >= kw_len(2'(k)) || in_byte_i != kw_char(2'(k), pos[3:0])) begin
                  alive_d[k] = 1'b0;
                end
              end
              step = 1'b1;
            end
          end
          PH_STAMP: begin
            if (col_q < UPD_PFX) begin
              fail = nl || (in_byte_i != upd_char(col_q[4:0]));
              step = !fail;
            end else if (nl) begin
              if (dig_q == '0) begin
                fail = 1'b1;
              end else begin
                phase_d = PH_DONE;
                col_d   = '0;
              end
            end else if (!(in_byte_i inside {[8'h30:8'h39]}) || dig_q >= DIG_MAX
                         || (|acc_x10[67:64])) begin
              fail = 1'b1;
            end else begin
              acc_d = acc_x10[63:0];
              dig_d = dig_q + 5'd1;
              step  = 1'b1;
            end
          end
          default: fail = 1'b1;
        endcase
        if (fail) begin
          bad_d = 1'b1;
        end else if (step && col_q < COL_SAT) begin
          col_d = col_q + COL_W'(1);
        end
      end
    end
  end

  // Parse registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      col_q   <= '0;
      bt_q    <= '0;
      bad_q   <= 1'b0;
      cnt_q   <= '0;
      alive_q <= 3'b111;
      acc_q   <= '0;
      dig_q   <= '0;
    end else begin
      phase_q <= phase_d;
      col_q   <= col_d;
      bt_q    <= bt_d;
      bad_q   <= bad_d;
      cnt_q   <= cnt_d;
      alive_q <= alive_d;
      acc_q   <= acc_d;
      dig_q   <= dig_d;
    end
  end

  // Threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stale_q <= '0;
    end else if (cfg_we_i) begin
      stale_q <= cfg_wdata_i;
    end
  end

  // Serial store
  srp_ram #(
    .WIDTH (8),
    .DEPTH (SERIAL_MAX)
  ) u_serial_ram (
    .clk_i   (clk_i),
    .we_i    (ser_we),
    .waddr_i (cnt_q[SER_AW-1:0]),
    .wdata_i (in_byte_i),
    .re_i    (cmd_i.rd),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  // Evaluation: future test and age, then visibility
  always_comb begin
    eval_ok  = !bad_q && (phase_q == PH_DONE) && (stale_q != '0) && !future_q;
    conn_sel = CONN_UNKNOWN;
    for (int k = 0; k < 3; k++) begin
      if (alive_q[k]) conn_sel = kw_code(2'(k));
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_now) now_q <= now_ms_i;
    if (cmd_i.check) begin
      future_q <= (acc_q > now_q);
      diff_q   <= now_q - acc_q;
    end
    if (cmd_i.judge) begin
      if (eval_ok) begin
        len_q <= cnt_q;
        upd_q <= acc_q;
        if (diff_q > stale_q) begin
          vis_q  <= VIS_STALE;
          conn_q <= CONN_UNKNOWN;
        end else begin
          vis_q  <= VIS_FRESH;
          conn_q <= conn_sel;
        end
      end else begin
        len_q  <= '0;
        upd_q  <= '0;
        vis_q  <= VIS_HIDDEN;
        conn_q <= CONN_UNKNOWN;
      end
    end
  end

  // Serial position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.clear) begin
      idx_q <= '0;
    end else if (cmd_i.next_idx) begin
      idx_q <= idx_q + SER_AW'(1);
    end
  end

  assign sts_o.len_zero = (len_q == '0);
  assign sts_o.idx_last = ((SER_CW'(idx_q) + SER_CW'(1)) == len_q);

  // Output beat fields
  assign serial_char_o   = cmd_i.sum_sel ? 8'h00 : ram_rdata;
  assign serial_index_o  = cmd_i.sum_sel ? 5'd0 : 5'(idx_q);
  assign serial_length_o = 6'(len_q);
  assign visibility_o    = vis_q;
  assign connection_o    = conn_q;
  assign updated_ms_o    = upd_q;
  assign final_item_o    = cmd_i.sum_sel;

endmodule
